// ===== hdl/rbd_pkg.sv =====
// Shared types and constants of the retry backoff delay block.
// Used by rbd_mulc and retry_backoff_delay; depends on nothing else.

package rbd_pkg;

	// Default field widths
	localparam int TIME_BITS_DEF   = 24;
	localparam int JITTER_BITS_DEF = 16;
	localparam int ATTEMPT_W       = 8;
	localparam int SEED_W          = 64;
	localparam int JFRAC_W         = 17;
	localparam int STATUS_W        = 2;
	localparam int CFG_IDX_W       = 3;

	// Q1.16 one
	localparam logic [JFRAC_W-1:0] ONE_Q16 = 17'h10000;

	// splitmix64 finalizer constants
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam int          MIX_SH1 = 30;
	localparam int          MIX_SH2 = 27;
	localparam int          MIX_SH3 = 31;

	// Exponent cap of the base shift
	localparam int E_CAP = 62;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RA_LIMIT     = 3'd4;

	// Register reset values
	localparam int RST_MAX_ATTEMPTS = 3;
	localparam int RST_INITIAL      = 100;
	localparam int RST_MAXIMUM      = 10000;
	localparam int RST_JITTER       = 16384;
	localparam int RST_RA_LIMIT     = 60000;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LATE = 2'd2;

	// Stage enables of the two-stage constant multiplier
	typedef struct packed {
		logic a;	// partial product stage
		logic b;	// sum stage
	} mul_en_t;

endpackage

// ===== hdl/retry_backoff_delay.sv =====
// Retry backoff delay: exponential backoff with splitmix64 jitter.
// One request per cycle while the result output is not stalled.
// Eight register stages: policy check and mixer prep, two 64-bit constant
// multiplies of two stages each, jitter product, delta product, final select.
// Reset clears stage valid bits and loads the register defaults; no state is
// kept between requests. Depends on rbd_pkg and rbd_mulc.

module retry_backoff_delay #(
	parameter int TIME_BITS   = rbd_pkg::TIME_BITS_DEF,
	parameter int JITTER_BITS = rbd_pkg::JITTER_BITS_DEF,
	localparam int CFG_W = (TIME_BITS > rbd_pkg::JFRAC_W) ? TIME_BITS : rbd_pkg::JFRAC_W,
	localparam int IN_W  = ((rbd_pkg::ATTEMPT_W + rbd_pkg::SEED_W + 2 * TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((rbd_pkg::STATUS_W + TIME_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,	// attempt_number, seed, retry_after_hint, remaining_deadline
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata	// status, delay
);

	localparam int NST = 8;
	localparam int AW  = rbd_pkg::ATTEMPT_W;
	localparam int JW  = rbd_pkg::JFRAC_W;
	localparam int JPW = JW + JITTER_BITS + 1;
	localparam int DPW = TIME_BITS + JW;

	// Configuration registers
	logic [AW-1:0]        max_att_q;
	logic [TIME_BITS-1:0] init_q;
	logic [TIME_BITS-1:0] maxb_q;
	logic [JW-1:0]        jfrac_q;
	logic [TIME_BITS-1:0] ralim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= AW'(rbd_pkg::RST_MAX_ATTEMPTS);
			init_q    <= TIME_BITS'(rbd_pkg::RST_INITIAL);
			maxb_q    <= TIME_BITS'(rbd_pkg::RST_MAXIMUM);
			jfrac_q   <= JW'(rbd_pkg::RST_JITTER);
			ralim_q   <= TIME_BITS'(rbd_pkg::RST_RA_LIMIT);
		end else if (cfg_we) begin
			case (cfg_index)
				rbd_pkg::REG_MAX_ATTEMPTS: max_att_q <= cfg_data[AW-1:0];
				rbd_pkg::REG_INITIAL:      init_q    <= cfg_data[TIME_BITS-1:0];
				rbd_pkg::REG_MAXIMUM:      maxb_q    <= cfg_data[TIME_BITS-1:0];
				rbd_pkg::REG_JITTER:       jfrac_q   <= cfg_data[JW-1:0];
				rbd_pkg::REG_RA_LIMIT:     ralim_q   <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: a stage moves when it is empty or the next one moves
	logic [NST:1] vld_s;
	logic [NST:1] adv;

	always_comb begin
		adv[NST] = !vld_s[NST] || m_tready;
		for (int k = NST - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k + 1];
		end
	end

	assign s_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k - 1];
				end
			end
		end
	end

	// Request fields
	logic [AW-1:0]        ord_c;
	logic [63:0]          seed_c;
	logic [TIME_BITS-1:0] hint_c;
	logic [TIME_BITS-1:0] dl_c;

	assign ord_c  = s_tdata[AW-1:0];
	assign seed_c = s_tdata[AW+63:AW];
	assign hint_c = s_tdata[AW+64+TIME_BITS-1:AW+64];
	assign dl_c   = s_tdata[AW+64+2*TIME_BITS-1:AW+64+TIME_BITS];

	// Stage 1: policy check, base delay, hint clamp, mixer seed
	logic [AW-1:0]        ordm1_c;
	logic [5:0]           e_c;
	logic [TIME_BITS-1:0] base_c;
	logic [TIME_BITS-1:0] prov_c;
	logic                 bad_c;
	logic [63:0]          gold_c;
	logic [63:0]          x0_c;
	logic [63:0]          x1_s1;

	always_comb begin
		ordm1_c = ord_c - AW'(1);
		e_c     = (ordm1_c > AW'(rbd_pkg::E_CAP)) ? 6'(rbd_pkg::E_CAP) : ordm1_c[5:0];
		if (init_q > (maxb_q >> e_c)) begin
			base_c = maxb_q;
		end else begin
			base_c = init_q << e_c;
		end
		prov_c = (hint_c < ralim_q) ? hint_c : ralim_q;
		bad_c  = (maxb_q < init_q) || (jfrac_q > rbd_pkg::ONE_Q16) ||
		         (ord_c == '0) || (ord_c > max_att_q) || (dl_c == '0);
		gold_c = {{(64-AW){1'b0}}, ord_c} * rbd_pkg::GOLDEN;
		x0_c   = seed_c ^ gold_c;
	end

	// Side fields carried along the pipe
	logic                 bad_s  [1:NST-1];
	logic [TIME_BITS-1:0] base_s [1:NST-1];
	logic [TIME_BITS-1:0] prov_s [1:NST-1];
	logic [TIME_BITS-1:0] dl_s   [1:NST-1];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x1_s1     <= x0_c ^ (x0_c >> rbd_pkg::MIX_SH1);
			bad_s[1]  <= bad_c;
			base_s[1] <= base_c;
			prov_s[1] <= prov_c;
			dl_s[1]   <= dl_c;
		end
		for (int k = 2; k <= NST - 1; k++) begin
			if (adv[k]) begin
				bad_s[k]  <= bad_s[k - 1];
				base_s[k] <= base_s[k - 1];
				prov_s[k] <= prov_s[k - 1];
				dl_s[k]   <= dl_s[k - 1];
			end
		end
	end

	// Stages 2-3: first finalizer multiply
	rbd_pkg::mul_en_t en1;
	rbd_pkg::mul_en_t en2;
	logic [63:0]      p1_s3;
	logic [63:0]      x2_c;
	logic [63:0]      p2_s5;

	assign en1.a = adv[2];
	assign en1.b = adv[3];
	assign en2.a = adv[4];
	assign en2.b = adv[5];

	rbd_mulc #(
		.MUL_CONST (rbd_pkg::MIX_C1)
	) u_mul1 (
		.clk (clk),
		.en  (en1),
		.x   (x1_s1),
		.y   (p1_s3)
	);

	// Stages 4-5: second finalizer multiply
	assign x2_c = p1_s3 ^ (p1_s3 >> rbd_pkg::MIX_SH2);

	rbd_mulc #(
		.MUL_CONST (rbd_pkg::MIX_C2)
	) u_mul2 (
		.clk (clk),
		.en  (en2),
		.x   (x2_c),
		.y   (p2_s5)
	);

	// Stage 6: unit from top bits, distance from one half, times J
	logic [63:0]            z_c;
	logic [JITTER_BITS-1:0] u_c;
	logic [JITTER_BITS:0]   two_u_c;
	logic [JITTER_BITS:0]   half_c;
	logic [JITTER_BITS:0]   mag_c;
	logic                   up_c;
	logic [JPW-1:0]         jprod_s6;
	logic                   up_s6;

	always_comb begin
		z_c     = p2_s5 ^ (p2_s5 >> rbd_pkg::MIX_SH3);
		u_c     = z_c[63 -: JITTER_BITS];
		two_u_c = {u_c, 1'b0};
		half_c  = {1'b1, {JITTER_BITS{1'b0}}};
		up_c    = u_c[JITTER_BITS-1];
		mag_c   = up_c ? (two_u_c - half_c) : (half_c - two_u_c);
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			jprod_s6 <= JPW'(jfrac_q) * JPW'(mag_c);
			up_s6    <= up_c;
		end
	end

	// Stage 7: base times Q1.16 jitter magnitude
	logic [JW-1:0]  m_c;
	logic [DPW-1:0] dprod_s7;
	logic           up_s7;

	assign m_c = jprod_s6[JITTER_BITS+JW-1:JITTER_BITS];

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			dprod_s7 <= DPW'(base_s[6]) * DPW'(m_c);
			up_s7    <= up_s6;
		end
	end

	// Stage 8: apply delta, clamp, take hint, check deadline
	logic [TIME_BITS-1:0]        delta_c;
	logic [TIME_BITS:0]          scaled_c;
	logic [TIME_BITS-1:0]        clamp_c;
	logic [TIME_BITS-1:0]        delay_c;
	logic [rbd_pkg::STATUS_W-1:0] status_c;
	logic [TIME_BITS-1:0]        odelay_c;
	logic [rbd_pkg::STATUS_W-1:0] status_s8;
	logic [TIME_BITS-1:0]        delay_s8;

	always_comb begin
		// delta never exceeds base when J is at most one, since m is then at most one
		delta_c  = dprod_s7[TIME_BITS+15:16];
		scaled_c = up_s7 ? ({1'b0, base_s[7]} + {1'b0, delta_c})
		                 : ({1'b0, base_s[7]} - {1'b0, delta_c});
		clamp_c  = (scaled_c > {1'b0, maxb_q}) ? maxb_q : scaled_c[TIME_BITS-1:0];
		delay_c  = (clamp_c > prov_s[7]) ? clamp_c : prov_s[7];
		odelay_c = '0;
		if (bad_s[7]) begin
			status_c = rbd_pkg::ST_BAD;
		end else if (delay_c >= dl_s[7]) begin
			status_c = rbd_pkg::ST_LATE;
		end else begin
			status_c = rbd_pkg::ST_OK;
			odelay_c = delay_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			status_s8 <= status_c;
			delay_s8  <= odelay_c;
		end
	end

	assign m_tvalid = vld_s[NST];
	assign m_tdata  = OUT_W'({delay_s8, status_s8});

	// Full pipe with a stalled output must refuse new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_s) && !m_tready) |-> !s_tready)
		else $error("request taken while pipe is full and stalled");

	// An accepted request occupies stage 1 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s[1])
		else $error("accepted request lost at stage 1");

	// Only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_s8 == rbd_pkg::ST_OK || status_s8 == rbd_pkg::ST_BAD ||
		              status_s8 == rbd_pkg::ST_LATE))
		else $error("undefined status code");

	// A rejected request carries no delay
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s8 != rbd_pkg::ST_OK) |-> (delay_s8 == '0))
		else $error("rejected request with nonzero delay");

	// An accepted delay is bounded by the backoff ceiling or the hint limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s8 == rbd_pkg::ST_OK) |->
			(delay_s8 <= maxb_q || delay_s8 <= ralim_q))
		else $error("delay above ceiling and hint limit");

endmodule

// ===== hdl/rbd_mulc.sv =====
// 64-bit by constant multiplier, product truncated to 64 bits.
// Two register stages: 32x32 partial products, then the sum. Uses rbd_pkg.

module rbd_mulc #(
	parameter logic [63:0] MUL_CONST = rbd_pkg::MIX_C1
) (
	input  logic             clk,
	input  rbd_pkg::mul_en_t en,
	input  logic [63:0]      x,
	output logic [63:0]      y
);

	logic [63:0] pll_s1;
	logic [31:0] plh_s1;
	logic [31:0] phl_s1;
	logic [63:0] prod_s2;
	logic [63:0] pll_c;
	logic [63:0] plh_c;
	logic [63:0] phl_c;

	// Partial products; cross terms only need their low halves
	assign pll_c = x[31:0] * MUL_CONST[31:0];
	assign plh_c = x[31:0] * MUL_CONST[63:32];
	assign phl_c = x[63:32] * MUL_CONST[31:0];

	always_ff @(posedge clk) begin
		if (en.a) begin
			pll_s1 <= pll_c;
			plh_s1 <= plh_c[31:0];
			phl_s1 <= phl_c[31:0];
		end
	end

	// Sum stage
	always_ff @(posedge clk) begin
		if (en.b) begin
			prod_s2 <= pll_s1 + {plh_s1 + phl_s1, 32'd0};
		end
	end

	assign y = prod_s2;

endmodule
